// ===== hdl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TAB_STEP      = 4;

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int SUM_W  = ROW_W + COL_W + 1;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(row) * SUM_W'(SCREEN_WIDTH) + SUM_W'(col);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tcw_if.sv =====
`default_nettype none

interface tcw_req_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, req_type, char_code, read_row, read_col, input ready);
  modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_data;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;

  modport source (output valid, cell_data, cursor_row, cursor_col, input ready);
  modport sink   (input valid, cell_data, cursor_row, cursor_col, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/text_console_char_writer_core.sv =====
// A put item's result is registered in the cycle after accept; a read item's
// result is registered from ST_RD, after the registered cell RAM read.
// Throughput: one put per cycle while results are taken; a read or backspace
// holds off the next item in ST_RD or ST_BS2; newline on the last row runs a
// row copy, a drain state and a row clear. Reset: a clearing pass writes each
// cell as a blank in attribute 7, one per cycle; items wait until it ends.
`default_nettype none

module text_console_char_writer_core import tcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [ATTR_W-1:0] cfg_wdata,
  tcw_req_if.sink                req,
  tcw_rsp_if.source              rsp
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_BS2,
    ST_SC_COPY,
    ST_SC_DRAIN,
    ST_SC_CLR
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  cnt;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [ATTR_W-1:0]  color_attr;
  logic               rd_oob;
  logic [ADDR_W-1:0]  bs_addr;
  logic               copy_vld;
  logic [ADDR_W-1:0]  copy_addr;
  logic               rsp_valid;
  logic [CELL_W-1:0]  rsp_data;
  logic [ROW_W-1:0]   rsp_row;
  logic [COL_W-1:0]   rsp_col;

  logic               accept;
  logic               in_range;
  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   col_next;
  logic [COL_W-1:0]   col_dec;
  logic [COL_W:0]     col_inc;
  logic [COL_W:0]     tab_sum;
  logic [ROW_W:0]     row_inc;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [CELL_W-1:0]  rdata;

  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid      = rsp_valid;
  assign rsp.cell_data  = rsp_data;
  assign rsp.cursor_row = rsp_row;
  assign rsp.cursor_col = rsp_col;

  assign in_range = (req.read_row < ROW_W'(SCREEN_HEIGHT)) &&
                    (req.read_col < COL_W'(SCREEN_WIDTH));

  assign col_dec = (cur_col == '0) ? '0 : cur_col - COL_W'(1);
  assign col_inc = {1'b0, cur_col} + (COL_W+1)'(1);
  assign tab_sum = {1'b0, cur_col} + (COL_W+1)'(TAB_STEP);
  assign row_inc = {1'b0, cur_row} + (ROW_W+1)'(1);

  // cursor after a put
  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    case (req.char_code)
      CH_LF, CH_CR: begin
        col_next = '0;
        if (row_inc < (ROW_W+1)'(SCREEN_HEIGHT)) begin
          row_next = row_inc[ROW_W-1:0];
        end else begin
          row_next = ROW_W'(SCREEN_HEIGHT - 1);
        end
      end
      CH_TAB: begin
        if (tab_sum > (COL_W+1)'(SCREEN_WIDTH - 1)) begin
          col_next = COL_W'(SCREEN_WIDTH - 1);
        end else begin
          col_next = tab_sum[COL_W-1:0];
        end
      end
      CH_BS: begin
        col_next = col_dec;
      end
      default: begin
        if (col_inc >= (COL_W+1)'(SCREEN_WIDTH)) begin
          col_next = '0;
          // wraps to the top without scrolling
          if (row_inc >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
            row_next = '0;
          end else begin
            row_next = row_inc[ROW_W-1:0];
          end
        end else begin
          col_next = col_inc[COL_W-1:0];
        end
      end
    endcase
  end

  // RAM port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = {color_attr, CH_BLANK};
    raddr = cell_addr(req.read_row, req.read_col);
    case (state)
      ST_INIT: begin
        we    = 1'b1;
        wdata = RESET_CELL;
      end
      ST_IDLE: begin
        waddr = cell_addr(cur_row, cur_col);
        if (accept && req.req_type == REQ_PUT) begin
          case (req.char_code)
            CH_LF, CH_CR, CH_TAB: we = 1'b0;
            CH_BS:                we = 1'b1;
            default: begin
              we    = 1'b1;
              wdata = {color_attr, req.char_code};
            end
          endcase
        end
      end
      ST_BS2: begin
        we    = 1'b1;
        waddr = bs_addr;
      end
      ST_SC_COPY, ST_SC_DRAIN: begin
        raddr = cnt + ADDR_W'(SCREEN_WIDTH);
        we    = copy_vld;
        waddr = copy_addr;
        wdata = rdata;
      end
      ST_SC_CLR: begin
        we = 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      color_attr <= RESET_ATTR;
      copy_vld   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_attr <= cfg_wdata;
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      copy_vld  <= 1'b0;
      copy_addr <= cnt;
      case (state)
        ST_INIT: begin
          if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_READ) begin
              rd_oob <= !in_range;
              state  <= ST_RD;
            end else begin
              cur_row   <= row_next;
              cur_col   <= col_next;
              rsp_valid <= 1'b1;
              rsp_data  <= '0;
              rsp_row   <= row_next;
              rsp_col   <= col_next;
              case (req.char_code)
                CH_LF, CH_CR: begin
                  if (row_inc >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
                    cnt   <= '0;
                    state <= ST_SC_COPY;
                  end
                end
                CH_BS: begin
                  bs_addr <= cell_addr(cur_row, col_dec);
                  state   <= ST_BS2;
                end
                default: state <= ST_IDLE;
              endcase
            end
          end
        end
        ST_RD: begin
          rsp_valid <= 1'b1;
          rsp_data  <= rd_oob ? '0 : rdata;
          rsp_row   <= cur_row;
          rsp_col   <= cur_col;
          state     <= ST_IDLE;
        end
        ST_BS2: begin
          state <= ST_IDLE;
        end
        ST_SC_COPY: begin
          copy_vld <= 1'b1;
          if (cnt == ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1)) begin
            state <= ST_SC_DRAIN;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_SC_DRAIN: begin
          // last copied cell is written this cycle
          cnt   <= ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
          state <= ST_SC_CLR;
        end
        ST_SC_CLR: begin
          if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_READ) |-> ##2 rsp_valid)
    else $error("read item produced no result");

  a_put_result: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_PUT) |=> rsp_valid)
    else $error("put item produced no result");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row < ROW_W'(SCREEN_HEIGHT)) && (cur_col < COL_W'(SCREEN_WIDTH)))
    else $error("cursor out of screen");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> !we)
    else $error("cell write while a read is pending");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int PHASE_ITEMS   = 450;
  localparam int NUM_PHASES    = 4;
  localparam int SCROLL_CYCLES = CELL_COUNT + 8;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_PRINTED   = 100;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } req_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } rsp_item_t;

  typedef struct {
    req_item_t item;
    int        reps;
    bit        typed;
    rsp_item_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_char_writer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // shadow copy of the console state
  logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] shadow_attr;

  rsp_item_t pending_rsp [$];
  dir_row_t  dir_rows [$];
  int        err_count;
  int        rsp_count;
  int        idle_pct;
  int        hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(64'd40_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic report_err(input string msg);
    if (err_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic void put_cell(int unsigned r, int unsigned c, logic [CHAR_W-1:0] ch);
    if (r < SCREEN_HEIGHT && c < SCREEN_WIDTH) shadow_cells[r * SCREEN_WIDTH + c] = {shadow_attr, ch};
  endfunction

  function automatic rsp_item_t console_step(input req_item_t it);
    rsp_item_t r;
    r.cell_data = '0;
    if (it.req_type == REQ_PUT) begin
      case (it.char_code)
        CH_LF, CH_CR: begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= SCREEN_HEIGHT) begin
            for (int i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++)
              shadow_cells[i] = shadow_cells[i + SCREEN_WIDTH];
            for (int c = 0; c < SCREEN_WIDTH; c++) put_cell(SCREEN_HEIGHT - 1, c, CH_BLANK);
            cur_row = SCREEN_HEIGHT - 1;
          end
        end
        CH_TAB: begin
          cur_col += TAB_STEP;
          if (cur_col > SCREEN_WIDTH - 1) cur_col = SCREEN_WIDTH - 1;
        end
        CH_BS: begin
          put_cell(cur_row, cur_col, CH_BLANK);
          if (cur_col > 0) cur_col--;
          put_cell(cur_row, cur_col, CH_BLANK);
        end
        default: begin
          put_cell(cur_row, cur_col, it.char_code);
          cur_col++;
          if (cur_col >= SCREEN_WIDTH) begin
            cur_col = 0;
            cur_row++;
            // wraps to the top without scrolling
            if (cur_row >= SCREEN_HEIGHT) cur_row = 0;
          end
        end
      endcase
    end else if (it.read_row < SCREEN_HEIGHT && it.read_col < SCREEN_WIDTH) begin
      r.cell_data = shadow_cells[it.read_row * SCREEN_WIDTH + it.read_col];
    end
    r.cursor_row = ROW_W'(cur_row);
    r.cursor_col = COL_W'(cur_col);
    return r;
  endfunction

  function automatic void add_row(input logic rt, input logic [CHAR_W-1:0] ch,
                                  input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                  input int reps, input bit typed,
                                  input logic [CELL_W-1:0] cd,
                                  input logic [ROW_W-1:0] cr, input logic [COL_W-1:0] cc);
    dir_row_t d;
    d.item  = '{req_type: rt, char_code: ch, read_row: rr, read_col: rc};
    d.reps  = reps;
    d.typed = typed;
    d.want  = '{cell_data: cd, cursor_row: cr, cursor_col: cc};
    dir_rows.push_back(d);
  endfunction

  function automatic req_item_t rand_item();
    req_item_t it;
    int k;
    it.req_type  = ($urandom_range(99) < 35) ? REQ_READ : REQ_PUT;
    it.char_code = CHAR_W'($urandom_range(0, 255));
    it.read_row  = ROW_W'($urandom_range(0, 31));
    it.read_col  = COL_W'($urandom_range(0, 127));
    if (it.req_type == REQ_READ) begin
      // mostly in-range reads so written cells are seen
      if ($urandom_range(99) < 85) begin
        it.read_row = ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
        it.read_col = COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
      end
    end else begin
      k = $urandom_range(99);
      if (k < 4)       it.char_code = CH_LF;
      else if (k < 7)  it.char_code = CH_CR;
      else if (k < 13) it.char_code = CH_TAB;
      else if (k < 22) it.char_code = CH_BS;
    end
    return it;
  endfunction

  task automatic offer(input req_item_t it, input bit typed, input rsp_item_t want);
    rsp_item_t pred;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= it.req_type;
    req_ch.char_code <= it.char_code;
    req_ch.read_row  <= it.read_row;
    req_ch.read_col  <= it.read_col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = console_step(it);
    pending_rsp.push_back(typed ? want : pred);
  endtask

  // block may still be scrolling after its last result
  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (SCROLL_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_attr  = v;
  endtask

  initial begin : rsp_sink
    int n;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        report_err("result with no item pending");
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.cell_data !== want.cell_data)
          report_err($sformatf("result %0d cell_data got %h want %h",
                               rsp_count, rsp_ch.cell_data, want.cell_data));
        if (rsp_ch.cursor_row !== want.cursor_row)
          report_err($sformatf("result %0d cursor_row got %0d want %0d",
                               rsp_count, rsp_ch.cursor_row, want.cursor_row));
        if (rsp_ch.cursor_col !== want.cursor_col)
          report_err($sformatf("result %0d cursor_col got %0d want %0d",
                               rsp_count, rsp_ch.cursor_col, want.cursor_col));
      end
      rsp_count++;
    end
  end

  initial begin : stim
    logic [ATTR_W-1:0] phase_attr [NUM_PHASES];
    int                phase_idle [NUM_PHASES];
    rsp_item_t         none;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_PUT;
    req_ch.char_code   = '0;
    req_ch.read_row    = '0;
    req_ch.read_col    = '0;
    err_count          = 0;
    rsp_count          = 0;
    idle_pct           = 15;
    hold_request       = 0;
    none               = '0;
    shadow_attr        = RESET_ATTR;
    cur_row            = 0;
    cur_col            = 0;
    foreach (shadow_cells[i]) shadow_cells[i] = RESET_CELL;

    // after reset, extremes, out-of-range reads, every control code
    add_row(REQ_READ, 8'h00, 5'd0, 7'd0, 1, 1, RESET_CELL, 5'd0, 7'd0);
    add_row(REQ_READ, 8'h00, 5'd24, 7'd79, 1, 1, RESET_CELL, 5'd0, 7'd0);
    add_row(REQ_READ, 8'h00, 5'd25, 7'd0, 1, 1, '0, 5'd0, 7'd0);
    add_row(REQ_READ, 8'h00, 5'd0, 7'd80, 1, 1, '0, 5'd0, 7'd0);
    add_row(REQ_READ, 8'hFF, 5'd31, 7'd127, 1, 1, '0, 5'd0, 7'd0);
    add_row(REQ_PUT, CH_BS, 5'd31, 7'd127, 1, 1, '0, 5'd0, 7'd0);
    add_row(REQ_PUT, 8'h41, 5'd0, 7'd0, 1, 1, '0, 5'd0, 7'd1);
    add_row(REQ_READ, 8'h00, 5'd0, 7'd0, 1, 1, {RESET_ATTR, 8'h41}, 5'd0, 7'd1);
    add_row(REQ_PUT, CH_TAB, 5'd0, 7'd0, 1, 1, '0, 5'd0, 7'd5);
    add_row(REQ_PUT, 8'hFF, 5'd0, 7'd0, 1, 1, '0, 5'd0, 7'd6);
    add_row(REQ_PUT, 8'h00, 5'd0, 7'd0, 1, 1, '0, 5'd0, 7'd7);
    add_row(REQ_READ, 8'h00, 5'd0, 7'd5, 1, 1, {RESET_ATTR, 8'hFF}, 5'd0, 7'd7);
    add_row(REQ_PUT, CH_BS, 5'd0, 7'd0, 1, 1, '0, 5'd0, 7'd6);
    add_row(REQ_READ, 8'h00, 5'd0, 7'd6, 1, 1, RESET_CELL, 5'd0, 7'd6);
    add_row(REQ_PUT, CH_CR, 5'd0, 7'd0, 1, 1, '0, 5'd1, 7'd0);
    add_row(REQ_PUT, CH_LF, 5'd0, 7'd0, 1, 1, '0, 5'd2, 7'd0);
    add_row(REQ_PUT, CH_TAB, 5'd0, 7'd0, 20, 0, '0, '0, '0);
    add_row(REQ_PUT, 8'h5A, 5'd0, 7'd0, 1, 1, '0, 5'd3, 7'd0);
    add_row(REQ_READ, 8'h00, 5'd2, 7'd79, 1, 1, {RESET_ATTR, 8'h5A}, 5'd3, 7'd0);
    // walk down to the last row, then one scroll
    add_row(REQ_PUT, CH_LF, 5'd0, 7'd0, 22, 0, '0, '0, '0);
    add_row(REQ_READ, 8'h00, 5'd1, 7'd79, 1, 0, '0, '0, '0);
    // fill the last row and wrap to the top
    add_row(REQ_PUT, 8'h78, 5'd0, 7'd0, 80, 0, '0, '0, '0);
    add_row(REQ_READ, 8'h00, 5'd24, 7'd0, 1, 0, '0, '0, '0);
    add_row(REQ_PUT, CH_BS, 5'd0, 7'd0, 1, 0, '0, '0, '0);
    add_row(REQ_READ, 8'h00, 5'd0, 7'd0, 1, 0, '0, '0, '0);

    phase_attr[0] = 8'hFF;
    phase_attr[1] = 8'h00;
    phase_attr[2] = ATTR_W'($urandom_range(1, 254));
    phase_attr[3] = ATTR_W'($urandom_range(0, 255));
    phase_idle[0] = 20;
    phase_idle[1] = 30;
    phase_idle[2] = 10;
    phase_idle[3] = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      for (int r = 0; r < dir_rows[i].reps; r++)
        offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      write_attr(phase_attr[p]);
      idle_pct = phase_idle[p];
      // receiver stalls long enough to back up the input
      if (p == 1) hold_request = LONG_HOLD;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == PHASE_ITEMS / 2) begin
          req_ch.valid <= 1'b0;
          do @(posedge clk); while (pending_rsp.size() != 0);
        end
        offer(rand_item(), 1'b0, none);
      end
    end

    req_ch.valid <= 1'b0;
    for (int k = 0; k < 10 * CELL_COUNT && pending_rsp.size() != 0; k++) @(posedge clk);
    repeat (SCROLL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0)
      report_err($sformatf("%0d results never arrived", pending_rsp.size()));

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_ram.sv
hdl/text_console_char_writer_core.sv
tb/sv/tb.sv
